FILE: sv/ldm_pkg.sv
// Shared types, constants and fixed-point helpers for the lens distortion mapper.
// Used by every module and by the channel interfaces.
package ldm_pkg;

  localparam int PIX_W = 24;
  localparam int Q_W = 32;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int UNDISTORT_ITERATIONS_DEF = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKEW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_3 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TANGENTIAL = 3'd7;

  localparam logic signed [71:0] Q_MAX72 = 72'sd2147483647;
  localparam logic signed [71:0] Q_MIN72 = -72'sd2147483648;
  localparam logic signed [39:0] PIX_MAX40 = 40'sd8388607;
  localparam logic signed [39:0] PIX_MIN40 = -40'sd8388608;

  typedef struct packed {
    logic signed [31:0] v;
    logic               clip;
  } qsat_t;

  typedef struct packed {
    logic signed [23:0] v;
    logic               clip;
  } psat_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] p0x;
    logic signed [31:0] p0y;
    logic               flag;
  } item_t;

  function automatic qsat_t sat_q(input logic signed [71:0] v);
    qsat_t r;
    if (v > Q_MAX72) begin
      r.v = 32'sh7FFFFFFF;
      r.clip = 1'b1;
    end else if (v < Q_MIN72) begin
      r.v = 32'sh80000000;
      r.clip = 1'b1;
    end else begin
      r.v = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic psat_t sat_pix(input logic signed [39:0] v);
    psat_t r;
    if (v > PIX_MAX40) begin
      r.v = 24'sh7FFFFF;
      r.clip = 1'b1;
    end else if (v < PIX_MIN40) begin
      r.v = 24'sh800000;
      r.clip = 1'b1;
    end else begin
      r.v = v[23:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // Product of Q4.28 operands, returned as Q8.28, floor rounding.
  function automatic logic signed [35:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[63:28];
  endfunction

endpackage

FILE: sv/ldm_if.sv
// Valid/ready channel interfaces for coordinate words and mapped results.
// Depends on ldm_pkg for the field widths.
interface ldm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [ldm_pkg::PIX_W-1:0]   in_x;
  logic signed [ldm_pkg::PIX_W-1:0]   in_y;
  modport source(output valid, kind, in_x, in_y, input ready);
  modport sink(input valid, kind, in_x, in_y, output ready);
endinterface

interface ldm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ldm_pkg::PIX_W-1:0]   out_x;
  logic signed [ldm_pkg::PIX_W-1:0]   out_y;
  logic                               saturated;
  modport source(output valid, out_x, out_y, saturated, input ready);
  modport sink(input valid, out_x, out_y, saturated, output ready);
endinterface

FILE: sv/lens_distortion_mapping_top.sv
// Channel      Direction  Payload
// in_ch        sink       kind, in_x, in_y (Q15.8 pixel coordinate)
// out_ch       source     out_x, out_y (Q15.8), saturated
// cfg_*        write      cfg_index selects the register, cfg_data carries the value
//
// One word is accepted per clock while out_ch is not stalled. Its stages include the
// two 36-stage dividers and one 11-stage polynomial unit per iteration.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall on out_ch freezes every stage and in_ch.ready falls in the same cycle.
// Reset clears the valid bits and all configuration registers to zero.
module lens_distortion_mapping_top #(
  parameter int UNDISTORT_ITERATIONS = ldm_pkg::UNDISTORT_ITERATIONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ldm_in_if.sink                         in_ch,
  ldm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ldm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldm_pkg::CFG_W-1:0]      cfg_data
);
  import ldm_pkg::*;

  logic [47:0] focal_r;
  logic [23:0] cx_r, cy_r;
  logic [31:0] sk_r, k1_r, k2_r, k3_r;
  logic [63:0] tang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
      sk_r <= '0;
      k1_r <= '0;
      k2_r <= '0;
      k3_r <= '0;
      tang_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOCAL: begin
          focal_r <= cfg_data[47:0];
        end
        CFG_CENTER_X: begin
          cx_r <= cfg_data[23:0];
        end
        CFG_CENTER_Y: begin
          cy_r <= cfg_data[23:0];
        end
        CFG_SKEW: begin
          sk_r <= cfg_data[31:0];
        end
        CFG_RADIAL_1: begin
          k1_r <= cfg_data[31:0];
        end
        CFG_RADIAL_2: begin
          k2_r <= cfg_data[31:0];
        end
        CFG_RADIAL_3: begin
          k3_r <= cfg_data[31:0];
        end
        CFG_TANGENTIAL: begin
          tang_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  logic en;
  logic out_v;

  assign en = !out_v || out_ch.ready;
  assign in_ch.ready = en;

  logic  norm_v;
  item_t norm_item;

  ldm_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_ch.valid), .kind(in_ch.kind), .x(in_ch.in_x), .y(in_ch.in_y),
    .fx(focal_r[23:0]), .fy(focal_r[47:24]), .cx(cx_r), .cy(cy_r),
    .sk(signed'(sk_r)),
    .out_valid(norm_v), .out_item(norm_item)
  );

  logic  chain_v [UNDISTORT_ITERATIONS+1];
  item_t chain_item [UNDISTORT_ITERATIONS+1];

  assign chain_v[0] = norm_v;
  assign chain_item[0] = norm_item;

  for (genvar i = 0; i < UNDISTORT_ITERATIONS; i++) begin : g_iter
    ldm_dist #(.IS_FIRST(i == 0)) u_dist (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(chain_v[i]), .in_item(chain_item[i]),
      .k1(signed'(k1_r)), .k2(signed'(k2_r)), .k3(signed'(k3_r)),
      .p1(signed'(tang_r[31:0])), .p2(signed'(tang_r[63:32])),
      .out_valid(chain_v[i+1]), .out_item(chain_item[i+1])
    );
  end

  ldm_denorm u_denorm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(chain_v[UNDISTORT_ITERATIONS]), .in_item(chain_item[UNDISTORT_ITERATIONS]),
    .fx(focal_r[23:0]), .fy(focal_r[47:24]), .cx(cx_r), .cy(cy_r),
    .sk(signed'(sk_r)),
    .out_valid(out_v), .ox(out_ch.out_x), .oy(out_ch.out_y), .sat(out_ch.saturated)
  );

  assign out_ch.valid = out_v;

endmodule

FILE: sv/ldm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with Q4.28 saturation.
// Depends on ldm_pkg.
module ldm_div #(
  parameter int PW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [63:0]   num,
  input  logic [23:0]          den,
  input  logic [PW-1:0]        in_pay,
  output logic                 out_valid,
  output logic signed [31:0]   out_q,
  output logic                 out_clip,
  output logic [PW-1:0]        out_pay
);
  import ldm_pkg::*;

  localparam int QB = 33;

  logic          a_v_r, a_sign_r, a_nz_r;
  logic [63:0]   a_mag_r;
  logic [PW-1:0] a_pay_r;

  logic          v_r [QB+1];
  logic          sign_r [QB+1];
  logic          nz_r [QB+1];
  logic          ovf_r [QB+1];
  logic [23:0]   rem_r [QB+1];
  logic [QB-1:0] lo_r [QB+1];
  logic [QB-1:0] q_r [QB+1];
  logic [PW-1:0] pay_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sign_r <= num[63];
      a_nz_r <= (num != 64'sd0);
      a_mag_r <= num[63] ? 64'(-num) : 64'(num);
      a_pay_r <= in_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign_r[0] <= a_sign_r;
      nz_r[0] <= a_nz_r;
      ovf_r[0] <= (a_mag_r[63:33] >= 31'(den));
      rem_r[0] <= a_mag_r[56:33];
      lo_r[0] <= a_mag_r[32:0];
      q_r[0] <= '0;
      pay_r[0] <= a_pay_r;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [24:0] t;
    logic        ge;
    assign t = {rem_r[k], lo_r[k][QB-1]};
    assign ge = (t >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sign_r[k+1] <= sign_r[k];
        nz_r[k+1] <= nz_r[k];
        ovf_r[k+1] <= ovf_r[k];
        rem_r[k+1] <= ge ? 24'(t - {1'b0, den}) : t[23:0];
        lo_r[k+1] <= {lo_r[k][QB-2:0], 1'b0};
        q_r[k+1] <= {q_r[k][QB-2:0], ge};
        pay_r[k+1] <= pay_r[k];
      end
    end
  end

  logic signed [31:0] q_s;
  logic               clip_s;
  logic [QB-1:0]      qf;

  always_comb begin
    qf = q_r[QB];
    if (den == 24'd0) begin
      clip_s = 1'b1;
      if (sign_r[QB]) begin
        q_s = 32'sh80000000;
      end else if (nz_r[QB]) begin
        q_s = 32'sh7FFFFFFF;
      end else begin
        q_s = 32'sd0;
      end
    end else if (!sign_r[QB]) begin
      if (ovf_r[QB] || (qf > 33'h07FFFFFFF)) begin
        q_s = 32'sh7FFFFFFF;
        clip_s = 1'b1;
      end else begin
        q_s = 32'(qf);
        clip_s = 1'b0;
      end
    end else begin
      if (ovf_r[QB] || (qf > 33'h080000000)) begin
        q_s = 32'sh80000000;
        clip_s = 1'b1;
      end else begin
        q_s = -(32'(qf));
        clip_s = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= q_s;
      out_clip <= clip_s;
      out_pay <= pay_r[QB];
    end
  end

endmodule

FILE: sv/ldm_norm.sv
// Normalization pipeline: centre offset, vertical divide, skew removal, horizontal divide.
// Depends on ldm_pkg and ldm_div.
module ldm_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic                kind,
  input  logic signed [23:0]  x,
  input  logic signed [23:0]  y,
  input  logic [23:0]         fx,
  input  logic [23:0]         fy,
  input  logic [23:0]         cx,
  input  logic [23:0]         cy,
  input  logic signed [31:0]  sk,
  output logic                out_valid,
  output ldm_pkg::item_t      out_item
);
  import ldm_pkg::*;

  logic               n0_v_r, n0_kind_r;
  logic signed [25:0] n0_dx_r, n0_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_v_r <= 1'b0;
    end else if (en) begin
      n0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_kind_r <= kind;
      n0_dx_r <= 26'(x) - 26'(signed'({1'b0, cx}));
      n0_dy_r <= 26'(y) - 26'(signed'({1'b0, cy}));
    end
  end

  logic               dy_v;
  logic signed [31:0] ny;
  logic               ny_clip;
  logic [26:0]        dy_pay;

  ldm_div #(.PW(27)) u_div_y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(n0_v_r),
    .num(64'(signed'({n0_dy_r, 28'd0}))),
    .den(fy),
    .in_pay({n0_kind_r, n0_dx_r}),
    .out_valid(dy_v), .out_q(ny), .out_clip(ny_clip), .out_pay(dy_pay)
  );

  logic               m_v_r, m_kind_r, m_fl_r;
  logic signed [25:0] m_dx_r;
  logic signed [31:0] m_ny_r;
  logic signed [63:0] m_skm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= dy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_kind_r <= dy_pay[26];
      m_dx_r <= dy_pay[25:0];
      m_ny_r <= ny;
      m_fl_r <= ny_clip;
      m_skm_r <= 64'(sk) * 64'(ny);
    end
  end

  logic               s_v_r, s_kind_r, s_fl_r;
  logic signed [31:0] s_ny_r;
  logic signed [63:0] s_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (en) begin
      s_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_kind_r <= m_kind_r;
      s_ny_r <= m_ny_r;
      s_fl_r <= m_fl_r;
      s_num_r <= 64'(signed'({m_dx_r, 28'd0})) - m_skm_r;
    end
  end

  logic               nx_clip;
  logic signed [31:0] nx;
  logic [33:0]        dx_pay;

  ldm_div #(.PW(34)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s_v_r),
    .num(s_num_r),
    .den(fx),
    .in_pay({s_kind_r, s_ny_r, s_fl_r}),
    .out_valid(out_valid), .out_q(nx), .out_clip(nx_clip), .out_pay(dx_pay)
  );

  always_comb begin
    out_item.kind = dx_pay[33];
    out_item.px = nx;
    out_item.p0x = nx;
    out_item.py = dx_pay[32:1];
    out_item.p0y = dx_pay[32:1];
    out_item.flag = dx_pay[0] | nx_clip;
  end

endmodule

FILE: sv/ldm_dist.sv
// One pass of the radial and tangential distortion polynomial, then for kind 1
// the fixed-point correction step of the inverse mapping. Depends on ldm_pkg.
module ldm_dist #(
  parameter bit IS_FIRST = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  ldm_pkg::item_t      in_item,
  input  logic signed [31:0]  k1,
  input  logic signed [31:0]  k2,
  input  logic signed [31:0]  k3,
  input  logic signed [31:0]  p1,
  input  logic signed [31:0]  p2,
  output logic                out_valid,
  output ldm_pkg::item_t      out_item
);
  import ldm_pkg::*;

  localparam int STAGES = 11;

  logic [STAGES-1:0] v_r;
  item_t             it_r [STAGES];
  item_t             it_n [STAGES];
  logic              act [STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_act
    assign act[k] = it_r[k].kind | IS_FIRST;
    always_ff @(posedge clk) begin
      if (en) begin
        it_r[k] <= it_n[k];
      end
    end
  end

  logic signed [35:0] mxx_r, myy_r, mxy_r;
  logic signed [31:0] xx_r, yy_r, xy_r, r2_r;
  logic signed [35:0] r4m_r, k1r2_r, p1xy_r, p2xy_r;
  logic signed [31:0] tx_r, ty_r, r2b_r;
  logic signed [31:0] r4_r, r2c_r;
  logic signed [35:0] p2tx_r, p1ty_r, k1r2b_r, p1xyb_r, p2xyb_r;
  logic signed [35:0] r6m_r, k2r4_r, k1r2c_r;
  logic signed [37:0] dxt_r, dyt_r;
  logic signed [31:0] r6_r;
  logic signed [35:0] k1r2d_r, k2r4b_r;
  logic signed [37:0] dxtb_r, dytb_r;
  logic signed [35:0] k3r6_r, k1r2e_r, k2r4c_r;
  logic signed [37:0] dxtc_r, dytc_r;
  logic signed [31:0] a_r;
  logic signed [37:0] dxtd_r, dytd_r;
  logic signed [35:0] xa_r, ya_r;
  logic signed [37:0] dxte_r, dyte_r;
  logic signed [31:0] xd_r, yd_r;

  qsat_t xx_s, yy_s, xy_s, r2_s, tx_s, ty_s, r4_s, r6_s, a_s, xd_s, yd_s, ux_s, uy_s;

  always_comb begin
    xx_s = sat_q(72'(mxx_r));
    yy_s = sat_q(72'(myy_r));
    xy_s = sat_q(72'(mxy_r));
    r2_s = sat_q(72'(mxx_r) + 72'(myy_r));
    tx_s = sat_q(72'(r2_r) + 72'(xx_r) + 72'(xx_r));
    ty_s = sat_q(72'(r2_r) + 72'(yy_r) + 72'(yy_r));
    r4_s = sat_q(72'(r4m_r));
    r6_s = sat_q(72'(r6m_r));
    a_s = sat_q(72'(k1r2e_r) + 72'(k2r4c_r) + 72'(k3r6_r));
    xd_s = sat_q(72'(it_r[8].px) + 72'(xa_r) + 72'(dxte_r));
    yd_s = sat_q(72'(it_r[8].py) + 72'(ya_r) + 72'(dyte_r));
    ux_s = sat_q(72'(it_r[9].px) - 72'(xd_r) + 72'(it_r[9].p0x));
    uy_s = sat_q(72'(it_r[9].py) - 72'(yd_r) + 72'(it_r[9].p0y));
  end

  always_comb begin
    it_n[0] = in_item;
    for (int k = 1; k < STAGES; k++) begin
      it_n[k] = it_r[k-1];
    end
    it_n[1].flag = it_r[0].flag
                   | (act[0] & (xx_s.clip | yy_s.clip | xy_s.clip | r2_s.clip));
    it_n[2].flag = it_r[1].flag | (act[1] & (tx_s.clip | ty_s.clip));
    it_n[3].flag = it_r[2].flag | (act[2] & r4_s.clip);
    it_n[5].flag = it_r[4].flag | (act[4] & r6_s.clip);
    it_n[7].flag = it_r[6].flag | (act[6] & a_s.clip);
    it_n[9].flag = it_r[8].flag | (act[8] & (xd_s.clip | yd_s.clip));
    if (it_r[9].kind) begin
      it_n[10].px = ux_s.v;
      it_n[10].py = uy_s.v;
      it_n[10].flag = it_r[9].flag | ux_s.clip | uy_s.clip;
    end else if (IS_FIRST) begin
      it_n[10].px = xd_r;
      it_n[10].py = yd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mxx_r <= mulq(in_item.px, in_item.px);
      myy_r <= mulq(in_item.py, in_item.py);
      mxy_r <= mulq(in_item.px, in_item.py);

      xx_r <= xx_s.v;
      yy_r <= yy_s.v;
      xy_r <= xy_s.v;
      r2_r <= r2_s.v;

      r4m_r <= mulq(r2_r, r2_r);
      k1r2_r <= mulq(k1, r2_r);
      p1xy_r <= mulq(p1, xy_r);
      p2xy_r <= mulq(p2, xy_r);
      tx_r <= tx_s.v;
      ty_r <= ty_s.v;
      r2b_r <= r2_r;

      r4_r <= r4_s.v;
      r2c_r <= r2b_r;
      p2tx_r <= mulq(p2, tx_r);
      p1ty_r <= mulq(p1, ty_r);
      k1r2b_r <= k1r2_r;
      p1xyb_r <= p1xy_r;
      p2xyb_r <= p2xy_r;

      r6m_r <= mulq(r4_r, r2c_r);
      k2r4_r <= mulq(k2, r4_r);
      k1r2c_r <= k1r2b_r;
      dxt_r <= 38'(p1xyb_r) + 38'(p1xyb_r) + 38'(p2tx_r);
      dyt_r <= 38'(p1ty_r) + 38'(p2xyb_r) + 38'(p2xyb_r);

      r6_r <= r6_s.v;
      k1r2d_r <= k1r2c_r;
      k2r4b_r <= k2r4_r;
      dxtb_r <= dxt_r;
      dytb_r <= dyt_r;

      k3r6_r <= mulq(k3, r6_r);
      k1r2e_r <= k1r2d_r;
      k2r4c_r <= k2r4b_r;
      dxtc_r <= dxtb_r;
      dytc_r <= dytb_r;

      a_r <= a_s.v;
      dxtd_r <= dxtc_r;
      dytd_r <= dytc_r;

      xa_r <= mulq(it_r[7].px, a_r);
      ya_r <= mulq(it_r[7].py, a_r);
      dxte_r <= dxtd_r;
      dyte_r <= dytd_r;

      xd_r <= xd_s.v;
      yd_r <= yd_s.v;
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_item = it_r[STAGES-1];

endmodule

FILE: sv/ldm_denorm.sv
// Maps a normalized point back to pixel coordinates and holds the result word.
// Depends on ldm_pkg.
module ldm_denorm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  ldm_pkg::item_t      in_item,
  input  logic [23:0]         fx,
  input  logic [23:0]         fy,
  input  logic [23:0]         cx,
  input  logic [23:0]         cy,
  input  logic signed [31:0]  sk,
  output logic                out_valid,
  output logic signed [23:0]  ox,
  output logic signed [23:0]  oy,
  output logic                sat
);
  import ldm_pkg::*;

  logic               e1_v_r, e1_fl_r;
  logic signed [56:0] e1_mx_r, e1_my_r;
  logic signed [63:0] e1_ms_r;
  logic               e2_v_r, e2_fl_r;
  logic signed [64:0] e2_sx_r;
  logic signed [56:0] e2_my_r;
  psat_t              ox_s, oy_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      e1_v_r <= in_valid;
      e2_v_r <= e1_v_r;
      out_valid <= e2_v_r;
    end
  end

  always_comb begin
    ox_s = sat_pix(40'(e2_sx_r >>> 28) + 40'(signed'({1'b0, cx})));
    oy_s = sat_pix(40'(e2_my_r >>> 28) + 40'(signed'({1'b0, cy})));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_mx_r <= 57'(signed'({1'b0, fx})) * 57'(in_item.px);
      e1_my_r <= 57'(signed'({1'b0, fy})) * 57'(in_item.py);
      e1_ms_r <= 64'(sk) * 64'(in_item.py);
      e1_fl_r <= in_item.flag;
      e2_sx_r <= 65'(e1_mx_r) + 65'(e1_ms_r);
      e2_my_r <= e1_my_r;
      e2_fl_r <= e1_fl_r;
      ox <= ox_s.v;
      oy <= oy_s.v;
      sat <= e2_fl_r | ox_s.clip | oy_s.clip;
    end
  end

endmodule
